### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`else

`define ASSERT_IMPL(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### src/ubxp_pkg.sv
// ----------------------------------------------------------------------------
// UBX frame parser package
// Field widths, protocol constants, status codes and the result item type.
// ----------------------------------------------------------------------------
package ubxp_pkg;

   localparam int MAX_PAYLOAD_DEFAULT = 1024;

   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 3;
   localparam int LEN_W    = 16;
   localparam int FLEN_W   = 11;
   localparam int PINDEX_W = 10;

   localparam logic [BYTE_W-1:0] PRE_ONE = 8'hB5;
   localparam logic [BYTE_W-1:0] PRE_TWO = 8'h62;

   typedef enum logic [STATUS_W-1:0] {
      ST_NONE = 3'd0,
      ST_DATA = 3'd1,
      ST_GOOD = 3'd2,
      ST_BADA = 3'd3,
      ST_BADB = 3'd4,
      ST_LONG = 3'd5
   } status_type;

   typedef struct packed {
      status_type            status;
      logic [BYTE_W-1:0]     frame_class;
      logic [BYTE_W-1:0]     frame_id;
      logic [FLEN_W-1:0]     frame_length;
      logic [BYTE_W-1:0]     payload_byte;
      logic [PINDEX_W-1:0]   payload_index;
   } rsp_item_type;

endpackage

### src/ubxp_req_if.sv
// ----------------------------------------------------------------------------
// UBX parser request channel
// Carries one received byte per item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ubxp_req_if;
   import ubxp_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

### src/ubxp_rsp_if.sv
// ----------------------------------------------------------------------------
// UBX parser response channel
// Carries one parse result per item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ubxp_rsp_if;
   import ubxp_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [BYTE_W-1:0]   frame_class;
   logic [BYTE_W-1:0]   frame_id;
   logic [FLEN_W-1:0]   frame_length;
   logic [BYTE_W-1:0]   payload_byte;
   logic [PINDEX_W-1:0] payload_index;

   modport source (
      output valid, output status, output frame_class, output frame_id,
      output frame_length, output payload_byte, output payload_index,
      input ready
   );
   modport sink (
      input valid, input status, input frame_class, input frame_id,
      input frame_length, input payload_byte, input payload_index,
      output ready
   );
endinterface

### src/ubxp_core.sv
// ----------------------------------------------------------------------------
// UBX parser core
// Parse state machine, header capture, Fletcher-8 sums and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ubxp_core #(
   parameter int MAX_PAYLOAD = ubxp_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [ubxp_pkg::BYTE_W-1:0] rx_byte,
   output ubxp_pkg::rsp_item_type      rsp_item
);
   import ubxp_pkg::*;

   localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

   typedef enum logic [3:0] {
      S_HUNT    = 4'd0,
      S_PRE2    = 4'd1,
      S_CLASS   = 4'd2,
      S_ID      = 4'd3,
      S_LEN_LO  = 4'd4,
      S_LEN_HI  = 4'd5,
      S_PAYLOAD = 4'd6,
      S_CKA     = 4'd7,
      S_CKB     = 4'd8
   } step_type;

   step_type            step_ff, step_in;
   logic [BYTE_W-1:0]   class_ff, class_in;
   logic [BYTE_W-1:0]   id_ff, id_in;
   logic [BYTE_W-1:0]   sum_a_ff, sum_a_in;
   logic [BYTE_W-1:0]   sum_b_ff, sum_b_in;
   logic [LEN_W-1:0]    length_ff, length_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   status_type          status_ff, status_in;
   logic [BYTE_W-1:0]   pbyte_ff, pbyte_in;
   logic [PINDEX_W-1:0] pindex_ff, pindex_in;

   logic [BYTE_W-1:0]   sum_a_add;
   logic [BYTE_W-1:0]   sum_b_add;
   step_type            hunt_step;
   logic [LEN_W-1:0]    len_full;
   logic [CNT_W-1:0]    count_inc;
   logic [LEN_W-1:0]    count_inc_wide;
   logic [LEN_W-1:0]    count_now_wide;

   assign sum_a_add      = sum_a_ff + rx_byte;
   assign sum_b_add      = sum_b_ff + sum_a_add;
   assign hunt_step      = (rx_byte == PRE_ONE) ? S_PRE2 : S_HUNT;
   assign len_full       = {rx_byte, length_ff[BYTE_W-1:0]};
   assign count_inc      = count_ff + CNT_W'(1);
   assign count_inc_wide = LEN_W'(count_inc);
   assign count_now_wide = LEN_W'(count_ff);

   always_comb begin
      step_in   = step_ff;
      class_in  = class_ff;
      id_in     = id_ff;
      sum_a_in  = sum_a_ff;
      sum_b_in  = sum_b_ff;
      length_in = length_ff;
      count_in  = count_ff;
      status_in = ST_NONE;
      pbyte_in  = '0;
      pindex_in = '0;
      case (step_ff)
         S_PRE2: begin
            step_in = (rx_byte == PRE_TWO) ? S_CLASS : hunt_step;
         end
         S_CLASS: begin
            class_in = rx_byte;
            sum_a_in = rx_byte;
            sum_b_in = rx_byte;
            step_in  = S_ID;
         end
         S_ID: begin
            sum_a_in = sum_a_add;
            sum_b_in = sum_b_add;
            id_in    = rx_byte;
            step_in  = S_LEN_LO;
         end
         S_LEN_LO: begin
            sum_a_in  = sum_a_add;
            sum_b_in  = sum_b_add;
            length_in = LEN_W'(rx_byte);
            step_in   = S_LEN_HI;
         end
         S_LEN_HI: begin
            sum_a_in = sum_a_add;
            sum_b_in = sum_b_add;
            if (len_full > MAX_LEN) begin
               status_in = ST_LONG;
               length_in = '0;
               step_in   = hunt_step;
            end else begin
               length_in = len_full;
               count_in  = '0;
               step_in   = (len_full == '0) ? S_CKA : S_PAYLOAD;
            end
         end
         S_PAYLOAD: begin
            sum_a_in  = sum_a_add;
            sum_b_in  = sum_b_add;
            status_in = ST_DATA;
            pbyte_in  = rx_byte;
            pindex_in = count_now_wide[PINDEX_W-1:0];
            count_in  = count_inc;
            if (count_inc_wide == length_ff) begin
               step_in = S_CKA;
            end
         end
         S_CKA: begin
            if (rx_byte != sum_a_ff) begin
               status_in = ST_BADA;
               step_in   = hunt_step;
            end else begin
               step_in = S_CKB;
            end
         end
         S_CKB: begin
            step_in   = S_HUNT;
            status_in = (rx_byte == sum_b_ff) ? ST_GOOD : ST_BADB;
         end
         default: begin
            step_in = hunt_step;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= S_HUNT;
         class_ff  <= '0;
         id_ff     <= '0;
         length_ff <= '0;
         status_ff <= ST_NONE;
      end else if (advance) begin
         step_ff   <= step_in;
         class_ff  <= class_in;
         id_ff     <= id_in;
         length_ff <= length_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_a_ff  <= sum_a_in;
         sum_b_ff  <= sum_b_in;
         count_ff  <= count_in;
         pbyte_ff  <= pbyte_in;
         pindex_ff <= pindex_in;
      end
   end

   assign rsp_item.status        = status_ff;
   assign rsp_item.frame_class   = class_ff;
   assign rsp_item.frame_id      = id_ff;
   assign rsp_item.frame_length  = length_ff[FLEN_W-1:0];
   assign rsp_item.payload_byte  = pbyte_ff;
   assign rsp_item.payload_index = pindex_ff;

   `ASSERT_NEXT(a_payload_reports_data, clock, reset, advance && (step_ff == S_PAYLOAD), status_ff == ST_DATA)
   `ASSERT_IMPL(a_count_below_length, clock, reset, step_ff == S_PAYLOAD, (count_now_wide < length_ff) && (length_ff <= MAX_LEN))
   `ASSERT_NEXT(a_ckb_ends_frame, clock, reset, advance && (step_ff == S_CKB), step_ff == S_HUNT)
   `ASSERT_NEXT(a_hold_when_stalled, clock, reset, !advance, $stable(step_ff) && $stable(status_ff))

endmodule

### src/ubx_frame_parser.sv
// ----------------------------------------------------------------------------
// UBX frame parser
// Finds UBX frames in a byte stream, checks Fletcher-8 sums, streams payload.
// ----------------------------------------------------------------------------
// Takes one received byte per item and returns exactly one result item per
// byte, at a sustained rate of one item per clock while the output side does
// not stall. Each byte passes an input register, then a state update that
// writes the result register, so a result is valid once its byte has passed
// both the input register and the result register. The input register lets a
// new byte in while a result waits to be taken. frame_class, frame_id and
// frame_length show the header registers after the byte; payload_byte and
// payload_index are zero unless status reports a payload byte.
module ubx_frame_parser #(
   parameter int MAX_PAYLOAD = ubxp_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   ubxp_req_if.sink  req_chan,
   ubxp_rsp_if.source rsp_chan
);
   import ubxp_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              out_valid_ff, out_valid_in;
   logic              advance;
   logic              req_take;
   rsp_item_type      rsp_item;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take     = req_chan.valid && req_chan.ready;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.rx_byte;
      end
   end

   ubxp_core #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .rx_byte  (in_byte_ff),
      .rsp_item (rsp_item)
   );

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.status        = rsp_item.status;
   assign rsp_chan.frame_class   = rsp_item.frame_class;
   assign rsp_chan.frame_id      = rsp_item.frame_id;
   assign rsp_chan.frame_length  = rsp_item.frame_length;
   assign rsp_chan.payload_byte  = rsp_item.payload_byte;
   assign rsp_chan.payload_index = rsp_item.payload_index;

endmodule
